[rtl/imu_gfp_pkg.sv]
package imu_gfp_pkg;

	localparam int G_BITS = 12;
	localparam logic [G_BITS-1:0] G_MAX = 12'd4095;
	localparam logic [G_BITS-1:0] G_RESET = 12'd256;

	localparam int G_NUM = 100000;
	localparam int G_DEN = 980665;
	localparam longint G_SAT_MAG = ((longint'(1) << G_BITS) * G_DEN + G_NUM - 1) / G_NUM;
	// below G_SAT_MAG, floor(mag * G_NUM / G_DEN) equals (mag * G_RECIP) >> G_RECIP_SHIFT
	localparam int G_RECIP_SHIFT = 33;
	localparam logic [29:0] G_RECIP = 30'd875929558;
	localparam int G_PROD_W = 46;

	localparam int NUM_AXES = 6;
	localparam int AXIS_W = 3;
	localparam int CNT_W = 3;
	localparam int Q_DEPTH = 2;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [1:0] LVL_NORMAL = 2'd0;
	localparam logic [1:0] LVL_WARN = 2'd1;
	localparam logic [1:0] LVL_DANGER = 2'd2;

	localparam logic [15:0] ACCEL_ALPHA_RST = 16'd19661;
	localparam logic [15:0] GYRO_ALPHA_RST = 16'd55706;
	localparam logic [11:0] DANGER_LOW_RST = 12'd128;
	localparam logic [11:0] WARN_LOW_RST = 12'd205;
	localparam logic [11:0] WARN_HIGH_RST = 12'd512;
	localparam logic [11:0] DANGER_HIGH_RST = 12'd1024;

	typedef enum logic {
		ITEM_SAMPLE,
		ITEM_CLEAR
	} item_kind_t;

	typedef enum logic [2:0] {
		REG_ACCEL_ALPHA = 3'd0,
		REG_GYRO_ALPHA  = 3'd1,
		REG_DANGER_LOW  = 3'd2,
		REG_WARN_LOW    = 3'd3,
		REG_WARN_HIGH   = 3'd4,
		REG_DANGER_HIGH = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] accel_alpha;
		logic [15:0] gyro_alpha;
		logic [G_BITS-1:0] danger_low;
		logic [G_BITS-1:0] warn_low;
		logic [G_BITS-1:0] warn_high;
		logic [G_BITS-1:0] danger_high;
	} cfg_t;

	function automatic logic [1:0] level_of(input logic [G_BITS-1:0] g, input cfg_t c);
		logic [1:0] lvl;
		if (g < c.danger_low || g > c.danger_high) begin
			lvl = LVL_DANGER;
		end else if (g < c.warn_low || g > c.warn_high) begin
			lvl = LVL_WARN;
		end else begin
			lvl = LVL_NORMAL;
		end
		return lvl;
	endfunction

endpackage

[rtl/imu_gfp_ifs.sv]
interface imu_gfp_smp_if #(parameter int SAMPLE_BITS = 18);
	logic valid;
	logic ready;
	logic func;
	logic signed [SAMPLE_BITS-1:0] accel_x;
	logic signed [SAMPLE_BITS-1:0] accel_y;
	logic signed [SAMPLE_BITS-1:0] accel_z;
	logic signed [SAMPLE_BITS-1:0] gyro_x;
	logic signed [SAMPLE_BITS-1:0] gyro_y;
	logic signed [SAMPLE_BITS-1:0] gyro_z;

	modport source (output valid, func, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
		input ready);
	modport sink (input valid, func, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
		output ready);
endinterface

interface imu_gfp_res_if #(parameter int SAMPLE_BITS = 18);
	logic valid;
	logic ready;
	logic signed [SAMPLE_BITS-1:0] smooth_accel_x;
	logic signed [SAMPLE_BITS-1:0] smooth_accel_y;
	logic signed [SAMPLE_BITS-1:0] smooth_accel_z;
	logic signed [SAMPLE_BITS-1:0] smooth_gyro_x;
	logic signed [SAMPLE_BITS-1:0] smooth_gyro_y;
	logic signed [SAMPLE_BITS-1:0] smooth_gyro_z;
	logic [11:0] g_now;
	logic [11:0] g_peak;
	logic [1:0] g_level;

	modport source (output valid, smooth_accel_x, smooth_accel_y, smooth_accel_z,
		smooth_gyro_x, smooth_gyro_y, smooth_gyro_z, g_now, g_peak, g_level, input ready);
	modport sink (input valid, smooth_accel_x, smooth_accel_y, smooth_accel_z,
		smooth_gyro_x, smooth_gyro_y, smooth_gyro_z, g_now, g_peak, g_level, output ready);
endinterface

[rtl/imu_smoothing_g_force_peak.sv]
// The back end sequencer handles a sample in order: an EMA multiply for each of the six axes, a bit-serial
// square root of SAMPLE_BITS steps and one reciprocal multiply; a clear transaction goes straight to the
// result stage. The back end takes a new transaction only once it is through with the last one.
// A two-entry queue keeps accepting transactions while the back end works, until the queue is full.
// Reset: arst_n async active low; stores to zero, current and peak G to 1.0 G, registers to defaults.
module imu_smoothing_g_force_peak #(
	parameter int SAMPLE_BITS = 18,
	parameter int ALPHA_FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	imu_gfp_smp_if.sink sample,
	imu_gfp_res_if.source result,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [imu_gfp_pkg::PADDR_W-1:0] paddr,
	input  logic [imu_gfp_pkg::PDATA_W-1:0] pwdata,
	output logic [imu_gfp_pkg::PDATA_W-1:0] prdata,
	output logic pready
);

	imu_gfp_pkg::cfg_t cfg;
	logic hd_valid;
	logic hd_ready;
	imu_gfp_pkg::item_kind_t hd_kind;
	logic signed [SAMPLE_BITS-1:0] hd_samp [imu_gfp_pkg::NUM_AXES];

	imu_gfp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	imu_gfp_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.smp      (sample),
		.hd_valid (hd_valid),
		.hd_ready (hd_ready),
		.hd_kind  (hd_kind),
		.hd_samp  (hd_samp)
	);

	imu_gfp_core #(
		.SAMPLE_BITS     (SAMPLE_BITS),
		.ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.hd_valid (hd_valid),
		.hd_ready (hd_ready),
		.hd_kind  (hd_kind),
		.hd_samp  (hd_samp),
		.res      (result)
	);

`ifndef SYNTH
	a_peak_ge_now: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.g_peak >= result.g_now))
		else $error("peak G below current G");

	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> hd_valid)
		else $error("accepted transaction missing from queue");

	a_pop_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(hd_valid && hd_ready) |-> (!result.valid || result.ready))
		else $error("queue popped while result register occupied");
`endif

endmodule

[rtl/imu_gfp_regs.sv]
module imu_gfp_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [imu_gfp_pkg::PADDR_W-1:0] paddr,
	input  logic [imu_gfp_pkg::PDATA_W-1:0] pwdata,
	output logic [imu_gfp_pkg::PDATA_W-1:0] prdata,
	output logic pready,
	output imu_gfp_pkg::cfg_t cfg
);

	imu_gfp_pkg::cfg_t cfg_q;
	imu_gfp_pkg::reg_idx_t idx;
	logic wr_en;

	assign idx = imu_gfp_pkg::reg_idx_t'(paddr[imu_gfp_pkg::PADDR_W-1:2]);
	assign wr_en = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel_alpha <= imu_gfp_pkg::ACCEL_ALPHA_RST;
			cfg_q.gyro_alpha <= imu_gfp_pkg::GYRO_ALPHA_RST;
			cfg_q.danger_low <= imu_gfp_pkg::DANGER_LOW_RST;
			cfg_q.warn_low <= imu_gfp_pkg::WARN_LOW_RST;
			cfg_q.warn_high <= imu_gfp_pkg::WARN_HIGH_RST;
			cfg_q.danger_high <= imu_gfp_pkg::DANGER_HIGH_RST;
		end else if (wr_en) begin
			case (idx)
				imu_gfp_pkg::REG_ACCEL_ALPHA: cfg_q.accel_alpha <= pwdata[15:0];
				imu_gfp_pkg::REG_GYRO_ALPHA: cfg_q.gyro_alpha <= pwdata[15:0];
				imu_gfp_pkg::REG_DANGER_LOW: cfg_q.danger_low <= pwdata[11:0];
				imu_gfp_pkg::REG_WARN_LOW: cfg_q.warn_low <= pwdata[11:0];
				imu_gfp_pkg::REG_WARN_HIGH: cfg_q.warn_high <= pwdata[11:0];
				imu_gfp_pkg::REG_DANGER_HIGH: cfg_q.danger_high <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			imu_gfp_pkg::REG_ACCEL_ALPHA: prdata = imu_gfp_pkg::PDATA_W'(cfg_q.accel_alpha);
			imu_gfp_pkg::REG_GYRO_ALPHA: prdata = imu_gfp_pkg::PDATA_W'(cfg_q.gyro_alpha);
			imu_gfp_pkg::REG_DANGER_LOW: prdata = imu_gfp_pkg::PDATA_W'(cfg_q.danger_low);
			imu_gfp_pkg::REG_WARN_LOW: prdata = imu_gfp_pkg::PDATA_W'(cfg_q.warn_low);
			imu_gfp_pkg::REG_WARN_HIGH: prdata = imu_gfp_pkg::PDATA_W'(cfg_q.warn_high);
			imu_gfp_pkg::REG_DANGER_HIGH: prdata = imu_gfp_pkg::PDATA_W'(cfg_q.danger_high);
			default: prdata = '0;
		endcase
	end

endmodule

[rtl/imu_gfp_front.sv]
module imu_gfp_front #(
	parameter int SAMPLE_BITS = 18
) (
	input  logic clk,
	input  logic arst_n,
	imu_gfp_smp_if.sink smp,
	output logic hd_valid,
	input  logic hd_ready,
	output imu_gfp_pkg::item_kind_t hd_kind,
	output logic signed [SAMPLE_BITS-1:0] hd_samp [imu_gfp_pkg::NUM_AXES]
);

	localparam int QAW = (imu_gfp_pkg::Q_DEPTH > 1) ? $clog2(imu_gfp_pkg::Q_DEPTH) : 1;
	localparam int QCW = $clog2(imu_gfp_pkg::Q_DEPTH + 1);

	imu_gfp_pkg::item_kind_t kind_q [imu_gfp_pkg::Q_DEPTH];
	logic signed [SAMPLE_BITS-1:0] samp_q [imu_gfp_pkg::Q_DEPTH][imu_gfp_pkg::NUM_AXES];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] fill_q;
	logic push;
	logic pop;
	imu_gfp_pkg::item_kind_t kind_in;

	assign smp.ready = (fill_q != QCW'(imu_gfp_pkg::Q_DEPTH));
	assign hd_valid = (fill_q != '0);
	assign push = smp.valid && smp.ready;
	assign pop = hd_valid && hd_ready;
	assign kind_in = smp.func ? imu_gfp_pkg::ITEM_CLEAR : imu_gfp_pkg::ITEM_SAMPLE;
	assign hd_kind = kind_q[rd_ptr_q];

	always_comb begin
		for (int i = 0; i < imu_gfp_pkg::NUM_AXES; i++) begin
			hd_samp[i] = samp_q[rd_ptr_q][i];
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			kind_q[wr_ptr_q] <= kind_in;
			samp_q[wr_ptr_q][0] <= smp.accel_x;
			samp_q[wr_ptr_q][1] <= smp.accel_y;
			samp_q[wr_ptr_q][2] <= smp.accel_z;
			samp_q[wr_ptr_q][3] <= smp.gyro_x;
			samp_q[wr_ptr_q][4] <= smp.gyro_y;
			samp_q[wr_ptr_q][5] <= smp.gyro_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(imu_gfp_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(imu_gfp_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: fill_q <= fill_q + 1'b1;
				2'b01: fill_q <= fill_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

[rtl/imu_gfp_core.sv]
module imu_gfp_core #(
	parameter int SAMPLE_BITS = 18,
	parameter int ALPHA_FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  imu_gfp_pkg::cfg_t cfg,
	input  logic hd_valid,
	output logic hd_ready,
	input  imu_gfp_pkg::item_kind_t hd_kind,
	input  logic signed [SAMPLE_BITS-1:0] hd_samp [imu_gfp_pkg::NUM_AXES],
	imu_gfp_res_if.source res
);

	localparam int AW = ALPHA_FRAC_BITS + 1;
	localparam int SW = SAMPLE_BITS + ALPHA_FRAC_BITS;
	localparam int PW = SW + 3;
	localparam int SQW = 2 * SAMPLE_BITS;
	localparam int GB = imu_gfp_pkg::G_BITS;
	localparam int PRW = imu_gfp_pkg::G_PROD_W;
	localparam logic [AW-1:0] ONE = AW'(1) << ALPHA_FRAC_BITS;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EMA,
		ST_EMA_WB,
		ST_SQ,
		ST_SUM,
		ST_SQRT,
		ST_GMUL,
		ST_FIN
	} state_t;

	state_t state_q;
	logic [imu_gfp_pkg::CNT_W-1:0] cnt_q;
	logic [GB-1:0] cur_g_q;
	logic [GB-1:0] peak_g_q;
	logic res_valid_q;
	logic signed [SAMPLE_BITS-1:0] res_sm_q [imu_gfp_pkg::NUM_AXES];
	logic [GB-1:0] res_g_now_q;
	logic [GB-1:0] res_g_peak_q;
	logic [1:0] res_level_q;

	logic signed [SW-1:0] store_q [imu_gfp_pkg::NUM_AXES];
	logic signed [SAMPLE_BITS-1:0] smooth [imu_gfp_pkg::NUM_AXES];

	logic [imu_gfp_pkg::AXIS_W-1:0] axis;
	logic [15:0] alpha_raw;
	logic [AW-1:0] a_eff;
	logic [AW-1:0] keep;
	logic signed [SAMPLE_BITS-1:0] x_sel;
	logic signed [SW-1:0] st_sel;
	logic signed [SAMPLE_BITS-1:0] st_hi;
	logic [ALPHA_FRAC_BITS-1:0] st_lo;
	logic signed [AW+SAMPLE_BITS:0] p_ax_w;
	logic signed [AW+SAMPLE_BITS:0] p_kh_w;
	logic [AW+ALPHA_FRAC_BITS-1:0] p_kl_w;

	logic signed [AW+SAMPLE_BITS:0] p_ax_s1;
	logic signed [AW+SAMPLE_BITS:0] p_kh_s1;
	logic [AW+ALPHA_FRAC_BITS-1:0] p_kl_s1;
	logic [imu_gfp_pkg::AXIS_W-1:0] kidx_s1;
	logic valid_s1;
	logic signed [PW-1:0] ema_sum;

	logic signed [SQW-1:0] sq_w [3];
	logic [SQW-1:0] sq_q [3];
	logic [SQW-1:0] v_q;
	logic [SQW-1:0] r_q;
	logic [SQW-1:0] bit_q;
	logic [SQW-1:0] sq_try;

	logic sat_q;
	logic [PRW-1:0] prod_q;
	logic [15:0] mag16;
	logic out_free;
	logic [GB-1:0] g_new;
	logic [GB-1:0] g_sel;
	logic [GB-1:0] peak_nxt;

	assign axis = cnt_q[imu_gfp_pkg::AXIS_W-1:0];
	assign alpha_raw = (cnt_q < imu_gfp_pkg::CNT_W'(3)) ? cfg.accel_alpha : cfg.gyro_alpha;
	assign a_eff = (32'(alpha_raw) > 32'(ONE)) ? ONE : AW'(alpha_raw);
	assign keep = ONE - a_eff;
	assign x_sel = hd_samp[axis];
	assign st_sel = store_q[axis];
	assign st_hi = $signed(st_sel[SW-1:ALPHA_FRAC_BITS]);
	assign st_lo = st_sel[ALPHA_FRAC_BITS-1:0];
	assign p_ax_w = $signed({1'b0, a_eff}) * x_sel;
	assign p_kh_w = $signed({1'b0, keep}) * st_hi;
	assign p_kl_w = keep * st_lo;
	assign ema_sum = PW'(p_ax_s1) + PW'(p_kh_s1) + PW'(p_kl_s1 >> ALPHA_FRAC_BITS);

	always_comb begin
		for (int i = 0; i < imu_gfp_pkg::NUM_AXES; i++) begin
			smooth[i] = $signed(store_q[i][SW-1:ALPHA_FRAC_BITS]);
		end
		for (int i = 0; i < 3; i++) begin
			sq_w[i] = smooth[i] * smooth[i];
		end
	end

	assign sq_try = r_q + bit_q;
	assign mag16 = 16'(r_q);
	assign g_new = sat_q ? imu_gfp_pkg::G_MAX : prod_q[imu_gfp_pkg::G_RECIP_SHIFT +: GB];
	assign g_sel = (hd_kind == imu_gfp_pkg::ITEM_CLEAR) ? cur_g_q : g_new;
	assign peak_nxt = (hd_kind == imu_gfp_pkg::ITEM_CLEAR) ? cur_g_q :
		((g_new > peak_g_q) ? g_new : peak_g_q);
	assign out_free = !res_valid_q || res.ready;
	assign hd_ready = (state_q == ST_FIN) && out_free;

	assign res.valid = res_valid_q;
	assign res.smooth_accel_x = res_sm_q[0];
	assign res.smooth_accel_y = res_sm_q[1];
	assign res.smooth_accel_z = res_sm_q[2];
	assign res.smooth_gyro_x = res_sm_q[3];
	assign res.smooth_gyro_y = res_sm_q[4];
	assign res.smooth_gyro_z = res_sm_q[5];
	assign res.g_now = res_g_now_q;
	assign res.g_peak = res_g_peak_q;
	assign res.g_level = res_level_q;

	always_ff @(posedge clk) begin
		p_ax_s1 <= p_ax_w;
		p_kh_s1 <= p_kh_w;
		p_kl_s1 <= p_kl_w;
		kidx_s1 <= axis;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			for (int i = 0; i < imu_gfp_pkg::NUM_AXES; i++) begin
				store_q[i] <= '0;
			end
		end else begin
			valid_s1 <= (state_q == ST_EMA);
			if (valid_s1) begin
				store_q[kidx_s1] <= ema_sum[SW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_SQ: begin
				for (int i = 0; i < 3; i++) begin
					sq_q[i] <= sq_w[i];
				end
			end
			ST_SUM: begin
				v_q <= sq_q[0] + sq_q[1] + sq_q[2];
				r_q <= '0;
				bit_q <= SQW'(1) << (SQW - 2);
			end
			ST_SQRT: begin
				if (v_q >= sq_try) begin
					v_q <= v_q - sq_try;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_GMUL: begin
				sat_q <= (r_q >= SQW'(imu_gfp_pkg::G_SAT_MAG));
				prod_q <= PRW'(mag16) * PRW'(imu_gfp_pkg::G_RECIP);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			cur_g_q <= imu_gfp_pkg::G_RESET;
			peak_g_q <= imu_gfp_pkg::G_RESET;
			res_valid_q <= 1'b0;
			for (int i = 0; i < imu_gfp_pkg::NUM_AXES; i++) begin
				res_sm_q[i] <= '0;
			end
			res_g_now_q <= '0;
			res_g_peak_q <= '0;
			res_level_q <= imu_gfp_pkg::LVL_NORMAL;
		end else begin
			if (hd_ready) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (hd_valid) begin
						cnt_q <= '0;
						state_q <= (hd_kind == imu_gfp_pkg::ITEM_CLEAR) ? ST_FIN : ST_EMA;
					end
				end
				ST_EMA: begin
					if (cnt_q == imu_gfp_pkg::CNT_W'(imu_gfp_pkg::NUM_AXES - 1)) begin
						state_q <= ST_EMA_WB;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_EMA_WB: state_q <= ST_SQ;
				ST_SQ: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_SQRT;
				ST_SQRT: begin
					if (bit_q[0]) begin
						state_q <= ST_GMUL;
					end
				end
				ST_GMUL: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						for (int i = 0; i < imu_gfp_pkg::NUM_AXES; i++) begin
							res_sm_q[i] <= smooth[i];
						end
						res_g_now_q <= g_sel;
						res_g_peak_q <= peak_nxt;
						res_level_q <= imu_gfp_pkg::level_of(g_sel, cfg);
						cur_g_q <= g_sel;
						peak_g_q <= peak_nxt;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
